// File: rtl/core/hrn_pkg.sv
// Shared constants, status codes and controller/datapath handshake types for the HRN scheduler.
package hrn_pkg;

	localparam int TABLE_ENTRIES = 8;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam int STAT_W = 3;
	localparam logic [STAT_W-1:0] ST_ADDED      = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL       = 3'd1;
	localparam logic [STAT_W-1:0] ST_DISPATCHED = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd3;
	localparam logic [STAT_W-1:0] ST_ZERO_BURST = 3'd4;

	localparam logic KIND_ADD      = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	// One stored job
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] order;
	} entry_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic cap_in;
		logic idx_clr;
		logic idx_inc;
		logic do_add;
		logic min_clr;
		logic min_upd;
		logic clk_adj;
		logic best_clr;
		logic sel_mul;
		logic sel_cmp;
		logic fin;
		logic res_empty;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic idx_last;
		logic any;
		logic out_vld;
	} sts_t;

endpackage

// File: rtl/core/hrn_ctrl.sv
// Controller state machine sequencing add, arrival scan, ratio scan and result hand-off.
module hrn_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic           s_kind,
	input  logic           m_tready,
	input  hrn_pkg::sts_t  sts,
	output logic           s_tready,
	output hrn_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_MIN,
		S_ADJ,
		S_SMUL,
		S_SCMP,
		S_FIN,
		S_RESP
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;
	logic   out_free;

	assign accept   = s_tvalid && ready_q;
	assign out_free = !sts.out_vld || m_tready;
	assign s_tready = ready_q;

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.cap_in  = accept;
				cmd.idx_clr = accept;
				cmd.min_clr = accept;
			end
			S_ADD: begin
				cmd.do_add = 1'b1;
			end
			S_MIN: begin
				cmd.min_upd = 1'b1;
				cmd.idx_inc = !sts.idx_last;
			end
			S_ADJ: begin
				cmd.res_empty = !sts.any;
				cmd.clk_adj   = sts.any;
				cmd.idx_clr   = sts.any;
				cmd.best_clr  = sts.any;
			end
			S_SMUL: begin
				cmd.sel_mul = 1'b1;
			end
			S_SCMP: begin
				cmd.sel_cmp = 1'b1;
				cmd.idx_inc = !sts.idx_last;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
			end
			S_RESP: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Advance state and the input-ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ready_q <= 1'b0;
						state_q <= (s_kind == hrn_pkg::KIND_DISPATCH) ? S_MIN : S_ADD;
					end
				end
				S_ADD: begin
					state_q <= S_RESP;
				end
				S_MIN: begin
					if (sts.idx_last) begin
						state_q <= S_ADJ;
					end
				end
				S_ADJ: begin
					state_q <= sts.any ? S_SMUL : S_RESP;
				end
				S_SMUL: begin
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					state_q <= sts.idx_last ? S_FIN : S_SMUL;
				end
				S_FIN: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/hrn_dp.sv
// Datapath: job table, scan index, arrival and ratio scans, clock and output register.
module hrn_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hrn_pkg::cmd_t                cmd,
	input  logic [15:0]                  in_id,
	input  logic [15:0]                  in_arrival,
	input  logic [15:0]                  in_burst,
	input  logic                         m_tready,
	output hrn_pkg::sts_t                sts,
	output logic                         out_vld,
	output logic [hrn_pkg::STAT_W-1:0]   out_status,
	output logic [15:0]                  out_id,
	output logic [31:0]                  out_start,
	output logic [31:0]                  out_finish
);

	localparam int N = hrn_pkg::TABLE_ENTRIES;
	localparam int IW = hrn_pkg::IDX_W;

	// Job table and valid bits
	hrn_pkg::entry_t mem [N];
	logic [N-1:0]    vld_q;
	hrn_pkg::entry_t rd_q;

	logic [IW-1:0] idx_q;
	logic [IW-1:0] idx_nxt;

	// Captured request
	logic [15:0] in_id_q;
	logic [15:0] in_arr_q;
	logic [15:0] in_burst_q;

	logic [15:0] ins_cnt_q;
	logic [31:0] clk_q;

	// Arrival scan
	logic        any_q;
	logic        arrived_q;
	logic [15:0] earliest_q;

	// Best candidate so far
	logic          best_vld_q;
	logic [IW-1:0] best_idx_q;
	logic [15:0]   best_id_q;
	logic [15:0]   best_arr_q;
	logic [15:0]   best_burst_q;
	logic [15:0]   best_age_q;
	logic [32:0]   best_num_q;

	// Product stage
	logic [48:0] lhs_s1;
	logic [48:0] rhs_s1;
	logic [32:0] num_s1;
	logic        elig_s1;

	// Pending result and output register
	logic [hrn_pkg::STAT_W-1:0] res_status_q;
	logic [15:0]                res_id_q;
	logic [31:0]                res_start_q;
	logic [31:0]                res_fin_q;
	logic                       out_vld_q;
	logic [hrn_pkg::STAT_W-1:0] out_status_q;
	logic [15:0]                out_id_q;
	logic [31:0]                out_start_q;
	logic [31:0]                out_fin_q;

	logic          cur_vld;
	logic          cur_arrived;
	logic [32:0]   cand_num;
	logic [15:0]   cand_age;
	logic          better;
	logic          free_found;
	logic [IW-1:0] free_idx;
	logic [32:0]   fin_sum;
	logic [31:0]   fin_sat;

	assign idx_nxt = cmd.idx_clr ? '0 : (cmd.idx_inc ? idx_q + IW'(1) : idx_q);

	assign cur_vld     = vld_q[idx_q];
	assign cur_arrived = ({16'd0, rd_q.arrival} <= clk_q);
	assign cand_num    = {1'b0, clk_q - {16'd0, rd_q.arrival}} + {17'd0, rd_q.burst};
	assign cand_age    = ins_cnt_q - rd_q.order;

	// Exact ratio compare, then earlier arrival, then older insertion
	always_comb begin
		if (!best_vld_q || (lhs_s1 > rhs_s1)) begin
			better = 1'b1;
		end else if (lhs_s1 != rhs_s1) begin
			better = 1'b0;
		end else if (rd_q.arrival != best_arr_q) begin
			better = rd_q.arrival < best_arr_q;
		end else begin
			better = cand_age > best_age_q;
		end
	end

	// Find the lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = 0; i < N; i++) begin
			if (!free_found && !vld_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	// Saturating finish time
	assign fin_sum = {1'b0, clk_q} + {17'd0, best_burst_q};
	assign fin_sat = fin_sum[32] ? 32'hFFFF_FFFF : fin_sum[31:0];

	// Table storage with registered read at the next scan index
	always_ff @(posedge clk) begin
		if (cmd.do_add && (in_burst_q != 16'd0) && free_found) begin
			mem[free_idx] <= '{id: in_id_q, arrival: in_arr_q, burst: in_burst_q,
				order: ins_cnt_q};
		end
		rd_q <= mem[idx_nxt];
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			in_id_q    <= in_id;
			in_arr_q   <= in_arrival;
			in_burst_q <= in_burst;
		end
	end

	// Form both cross products against the current best
	always_ff @(posedge clk) begin
		if (cmd.sel_mul) begin
			lhs_s1  <= cand_num * best_burst_q;
			rhs_s1  <= best_num_q * rd_q.burst;
			num_s1  <= cand_num;
			elig_s1 <= cur_vld && cur_arrived;
		end
	end

	// Hold the best candidate payload
	always_ff @(posedge clk) begin
		if (cmd.sel_cmp && elig_s1 && better) begin
			best_idx_q   <= idx_q;
			best_id_q    <= rd_q.id;
			best_arr_q   <= rd_q.arrival;
			best_burst_q <= rd_q.burst;
			best_age_q   <= cand_age;
			best_num_q   <= num_s1;
		end
	end

	// Hold the pending result
	always_ff @(posedge clk) begin
		if (cmd.do_add) begin
			res_id_q    <= '0;
			res_start_q <= '0;
			res_fin_q   <= '0;
			if (in_burst_q == 16'd0) begin
				res_status_q <= hrn_pkg::ST_ZERO_BURST;
			end else if (!free_found) begin
				res_status_q <= hrn_pkg::ST_FULL;
			end else begin
				res_status_q <= hrn_pkg::ST_ADDED;
			end
		end else if (cmd.res_empty || (cmd.fin && !best_vld_q)) begin
			res_status_q <= hrn_pkg::ST_EMPTY;
			res_id_q     <= '0;
			res_start_q  <= '0;
			res_fin_q    <= '0;
		end else if (cmd.fin) begin
			res_status_q <= hrn_pkg::ST_DISPATCHED;
			res_id_q     <= best_id_q;
			res_start_q  <= clk_q;
			res_fin_q    <= fin_sat;
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_start_q  <= res_start_q;
			out_fin_q    <= res_fin_q;
		end
	end

	// Control state: index, valid bits, counters, clock, scan flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			vld_q      <= '0;
			ins_cnt_q  <= '0;
			clk_q      <= '0;
			any_q      <= 1'b0;
			arrived_q  <= 1'b0;
			earliest_q <= '0;
			best_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			idx_q <= idx_nxt;

			if (cmd.do_add && (in_burst_q != 16'd0) && free_found) begin
				vld_q[free_idx] <= 1'b1;
				ins_cnt_q       <= ins_cnt_q + 16'd1;
			end

			if (cmd.min_clr) begin
				any_q     <= 1'b0;
				arrived_q <= 1'b0;
			end else if (cmd.min_upd && cur_vld) begin
				any_q <= 1'b1;
				if (!any_q || (rd_q.arrival < earliest_q)) begin
					earliest_q <= rd_q.arrival;
				end
				if (cur_arrived) begin
					arrived_q <= 1'b1;
				end
			end

			if (cmd.clk_adj && !arrived_q) begin
				clk_q <= {16'd0, earliest_q};
			end

			if (cmd.best_clr) begin
				best_vld_q <= 1'b0;
			end else if (cmd.sel_cmp && elig_s1) begin
				best_vld_q <= 1'b1;
			end

			if (cmd.fin && best_vld_q) begin
				clk_q               <= fin_sat;
				vld_q[best_idx_q]   <= 1'b0;
			end

			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign sts.idx_last = (idx_q == IW'(N - 1));
	assign sts.any      = any_q;
	assign sts.out_vld  = out_vld_q;

	assign out_vld    = out_vld_q;
	assign out_status = out_status_q;
	assign out_id     = out_id_q;
	assign out_start  = out_start_q;
	assign out_finish = out_fin_q;

endmodule

// File: rtl/core/hrn_scheduler_select_core.sv
// Top level of the highest-response-ratio-next scheduler: stream ports, controller and datapath.
//
// Usage:
//   Slave stream s_*: one request per transfer. s_tuser[0] is the request kind
//   (0 add a job, 1 dispatch the next job); s_tdata carries job id, arrival
//   tick and burst length. Master stream m_*: exactly one result per request,
//   in request order. m_tuser[2:0] is the status code (0 added, 1 table full,
//   2 dispatched, 3 table empty, 4 zero burst rejected); m_tdata carries the
//   chosen job id, start time and saturating finish time.
//   Requests are taken one at a time. An add updates the table and then loads the
//   output register. A dispatch makes one arrival pass at one entry per cycle;
//   if any job is stored it then adjusts the clock, makes one ratio pass (product,
//   then compare, for each entry) through the table's single read port, finishes
//   and loads the output register; with an empty table it loads the empty result
//   directly. The next request is accepted from the cycle after its result is
//   loaded into the output register, even while that result still waits on m_tready.
//   Reset clears the table valid bits, the insertion counter and the scheduler
//   clock; the block is ready for a request as soon as reset is released.
//   When m_tready stays low, the result holds on m_*; one more request can be
//   taken and run, then s_tready stays low until the output register drains.
module hrn_scheduler_select_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // job_id[15:0], arrival_time[31:16], burst_length[47:32]
	input  logic [0:0]  s_tuser,  // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // chosen_id[15:0], start_time[47:16], finish_time[79:48]
	output logic [2:0]  m_tuser   // status[2:0]
);

	hrn_pkg::cmd_t cmd;
	hrn_pkg::sts_t sts;

	logic [hrn_pkg::STAT_W-1:0] out_status;
	logic [15:0]                out_id;
	logic [31:0]                out_start;
	logic [31:0]                out_finish;

	hrn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_kind   (s_tuser[0]),
		.m_tready (m_tready),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	hrn_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_id      (s_tdata[15:0]),
		.in_arrival (s_tdata[31:16]),
		.in_burst   (s_tdata[47:32]),
		.m_tready   (m_tready),
		.sts        (sts),
		.out_vld    (m_tvalid),
		.out_status (out_status),
		.out_id     (out_id),
		.out_start  (out_start),
		.out_finish (out_finish)
	);

	// Pack the result fields
	assign m_tdata = {out_finish, out_start, out_id};
	assign m_tuser = out_status;

endmodule

// File: bench/hrn_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the HRN scheduler: keeps its own job table and compares every result.
module hrn_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,  // job_id[15:0], arrival_time[31:16], burst_length[47:32]
	input  logic [0:0]  s_tuser,  // kind[0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,  // chosen_id[15:0], start_time[47:16], finish_time[79:48]
	input  logic [2:0]  m_tuser,  // status[2:0]
	output int          mismatch_count,
	output int          results_due_count,
	output int          results_checked
);
	import hrn_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [15:0]       job_id;
		logic [31:0]       start_time;
		logic [31:0]       finish_time;
	} sched_result_t;

	// Shadow job table and scheduler clock
	logic          slot_used [TABLE_ENTRIES];
	entry_t        slot_job  [TABLE_ENTRIES];
	logic [15:0]   adds_done;
	logic [31:0]   sched_now;
	sched_result_t results_due [$];
	int            mismatches;
	int            checks;

	// True when job a wins over job b at the current clock
	function automatic logic ranks_higher(input entry_t a, input entry_t b);
		logic [63:0] score_a;
		logic [63:0] score_b;
		logic [15:0] age_a;
		logic [15:0] age_b;
		// cross-multiply (wait + burst) / burst, no division
		score_a = (64'(sched_now) - 64'(a.arrival) + 64'(a.burst)) * 64'(b.burst);
		score_b = (64'(sched_now) - 64'(b.arrival) + 64'(b.burst)) * 64'(a.burst);
		age_a = adds_done - a.order;
		age_b = adds_done - b.order;
		if (score_a != score_b)
			return score_a > score_b;
		if (a.arrival != b.arrival)
			return a.arrival < b.arrival;
		return age_a > age_b;
	endfunction

	// Apply one request to the shadow table and return the result it should produce
	function automatic sched_result_t schedule_request(input logic kind, input logic [15:0] id,
			input logic [15:0] arrival, input logic [15:0] burst);
		sched_result_t res;
		int            free_slot;
		int            pick;
		logic          any_job;
		logic          any_arrived;
		logic [15:0]   earliest;
		logic [32:0]   done_at;
		res = '0;
		if (kind == KIND_ADD) begin
			// zero burst is rejected before the full test
			if (burst == 16'd0) begin
				res.status = ST_ZERO_BURST;
				return res;
			end
			free_slot = -1;
			for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
				if (!slot_used[i])
					free_slot = i;
			if (free_slot < 0) begin
				res.status = ST_FULL;
				return res;
			end
			slot_used[free_slot] = 1'b1;
			slot_job[free_slot]  = '{id: id, arrival: arrival, burst: burst, order: adds_done};
			adds_done = adds_done + 16'd1;
			res.status = ST_ADDED;
			return res;
		end
		// find earliest arrival and whether anything has arrived
		any_job = 1'b0;
		any_arrived = 1'b0;
		earliest = '1;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (slot_used[i]) begin
				any_job = 1'b1;
				if (slot_job[i].arrival < earliest)
					earliest = slot_job[i].arrival;
				if (32'(slot_job[i].arrival) <= sched_now)
					any_arrived = 1'b1;
			end
		end
		if (!any_job) begin
			res.status = ST_EMPTY;
			return res;
		end
		// idle until the first job shows up
		if (!any_arrived)
			sched_now = 32'(earliest);
		pick = -1;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (slot_used[i] && 32'(slot_job[i].arrival) <= sched_now)
				if (pick < 0 || ranks_higher(slot_job[i], slot_job[pick]))
					pick = i;
		// saturate the finish time
		done_at = 33'(sched_now) + 33'(slot_job[pick].burst);
		if (done_at[32])
			done_at = {1'b0, 32'hFFFF_FFFF};
		res.status      = ST_DISPATCHED;
		res.job_id      = slot_job[pick].id;
		res.start_time  = sched_now;
		res.finish_time = done_at[31:0];
		sched_now = done_at[31:0];
		slot_used[pick] = 1'b0;
		return res;
	endfunction

	function automatic void compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		end
	endfunction

	// Check results first, then predict the request taken at this edge
	always @(posedge clk or negedge arst_n) begin
		sched_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				slot_used[i] = 1'b0;
			adds_done = '0;
			sched_now = '0;
			results_due.delete();
			mismatches = 0;
			checks = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$error("status: expected no result, got %0d", m_tuser);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					compare_field("status", 32'(want.status), 32'(m_tuser));
					compare_field("chosen_id", 32'(want.job_id), 32'(m_tdata[15:0]));
					compare_field("start_time", want.start_time, m_tdata[47:16]);
					compare_field("finish_time", want.finish_time, m_tdata[79:48]);
					checks++;
				end
			end
			if (s_tvalid && s_tready)
				results_due.push_back(schedule_request(s_tuser[0], s_tdata[15:0],
					s_tdata[31:16], s_tdata[47:32]));
		end
		mismatch_count    <= mismatches;
		results_due_count <= results_due.size();
		results_checked   <= checks;
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Top of the HRN scheduler bench: clock, reset, request stimulus, result stalls and verdict.
module testbench;
	import hrn_pkg::*;

	localparam int ITEM_COUNT   = 950;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 3 * TABLE_ENTRIES + 21;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic [2:0]  m_tuser;

	int   mismatch_count;
	int   results_due_count;
	int   results_checked;
	int   cycle_count = 0;
	int   adds_sent = 0;
	int   dispatches_sent = 0;
	logic quiet_phase = 1'b0;

	hrn_scheduler_select_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	hrn_result_checker result_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tuser           (s_tuser),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.m_tuser           (m_tuser),
		.mismatch_count    (mismatch_count),
		.results_due_count (results_due_count),
		.results_checked   (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Offer one request after a random gap and hold it until taken
	task automatic send_request(input logic kind, input logic [15:0] id,
			input logic [15:0] arrival, input logic [15:0] burst);
		int gap;
		gap = quiet_phase ? 0 : $urandom_range(7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {burst, arrival, id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (kind == KIND_ADD)
			adds_sent++;
		else
			dispatches_sent++;
	endtask

	// Stall the result side for a random count before each result
	initial begin
		int stall;
		m_tready = 1'b0;
		do
			@(posedge clk);
		while (!arst_n);
		forever begin
			stall = quiet_phase ? 0 : $urandom_range(7);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	initial begin
		int          random_sent;
		int          add_run;
		int          dispatch_run;
		int          pick;
		int          arrival_floor;
		logic        wide;
		logic [15:0] burst;
		logic [15:0] arrival;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		random_sent = 0;
		arrival_floor = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, zero burst, then idle until the first arrival
		send_request(KIND_DISPATCH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(KIND_ADD, 16'h0000, 16'd40, 16'd0);
		send_request(KIND_ADD, 16'h0001, 16'd40, 16'd4);
		send_request(KIND_ADD, 16'h0002, 16'd30, 16'd8);
		send_request(KIND_DISPATCH, 16'h0000, 16'h0000, 16'h0000);
		// Equal ratios: earlier arrival beats earlier insertion, then insertion order
		send_request(KIND_ADD, 16'h0012, 16'd24, 16'd3);
		send_request(KIND_ADD, 16'h0010, 16'd10, 16'd6);
		send_request(KIND_ADD, 16'h0011, 16'd10, 16'd6);
		send_request(KIND_DISPATCH, 16'h0000, 16'h0000, 16'h0000);
		send_request(KIND_DISPATCH, 16'h0000, 16'h0000, 16'h0000);
		// Fill the table, overflow it, and reject a zero burst while full
		send_request(KIND_ADD, 16'hFFFF, 16'd0, 16'd1);
		send_request(KIND_ADD, 16'h5555, 16'd47, 16'd2);
		send_request(KIND_ADD, 16'hAAAA, 16'd47, 16'd2);
		send_request(KIND_ADD, 16'h00FF, 16'd100, 16'h00FF);
		send_request(KIND_ADD, 16'hFF00, 16'd200, 16'h0F0F);
		send_request(KIND_ADD, 16'h7FFF, 16'd47, 16'h0100);
		send_request(KIND_ADD, 16'h0BAD, 16'd1, 16'd1);
		send_request(KIND_ADD, 16'h0BAD, 16'd1, 16'd0);
		repeat (4) send_request(KIND_DISPATCH, 16'h0000, 16'h0000, 16'h0000);

		// Random runs of adds and dispatches, full-range values near the end
		while (random_sent < ITEM_COUNT) begin
			if ($urandom_range(5) == 0)
				quiet_phase <= ~quiet_phase;
			add_run = $urandom_range(1, 10);
			dispatch_run = $urandom_range(1, 10);
			wide = (random_sent >= ITEM_COUNT * 4 / 5);
			// stray request of either kind with tiny bursts
			if ($urandom_range(7) == 0) begin
				arrival = wide ? 16'($urandom) : 16'($urandom_range(arrival_floor,
					arrival_floor + 2047));
				send_request(1'($urandom_range(1)), 16'($urandom), arrival,
					16'($urandom_range(3)));
				random_sent++;
			end
			repeat (add_run) begin
				pick = $urandom_range(99);
				if (pick < 5)
					burst = 16'd0;
				else if (pick < 75)
					burst = 16'($urandom_range(1, 15));
				else if (!wide)
					burst = 16'($urandom_range(1, 255));
				else
					burst = 16'($urandom_range(1, 16'hFFFF));
				if (wide)
					arrival = 16'($urandom);
				else
					arrival = 16'($urandom_range(arrival_floor, arrival_floor + 2047));
				send_request(KIND_ADD, 16'($urandom), arrival, burst);
			end
			repeat (dispatch_run)
				send_request(KIND_DISPATCH, 16'($urandom), 16'($urandom), 16'($urandom));
			random_sent += add_run + dispatch_run;
			arrival_floor = random_sent * 16;
		end

		// All-ones and minimum fields, then drain past empty
		send_request(KIND_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(KIND_ADD, 16'h0000, 16'h0000, 16'd1);
		repeat (TABLE_ENTRIES + 2)
			send_request(KIND_DISPATCH, 16'h0000, 16'h0000, 16'h0000);
		s_tvalid <= 1'b0;

		// Wait for outstanding results, then let the pipe settle
		@(posedge clk);
		while (results_due_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d adds, %0d dispatches), checked %0d results",
			adds_sent + dispatches_sent, adds_sent, dispatches_sent, results_checked);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/hrn_pkg.sv
rtl/core/hrn_ctrl.sv
rtl/core/hrn_dp.sv
rtl/core/hrn_scheduler_select_core.sv
bench/hrn_result_checker.sv
bench/testbench.sv
